// ===== rtl/core/swi_pkg.sv =====
package swi_pkg;

  localparam int unsigned TableDepthDefault = 64;
  localparam int unsigned PosW   = 32;
  localparam int unsigned WidW   = 16;
  localparam int unsigned EntryW = PosW + WidW;
  localparam int unsigned ProdW  = PosW + WidW;
  localparam int unsigned AccW   = ProdW + 2;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_EXEC, ST_SETUP, ST_W0, ST_C0, ST_W1, ST_C1,
    ST_BS, ST_BW, ST_BC, ST_LW, ST_LC, ST_HW, ST_HC,
    ST_M1, ST_M2, ST_M3, ST_DIV, ST_FIN
  } state_e;

endpackage

// ===== rtl/core/swi_ram.sv =====
module swi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/sampled_width_interpolator.sv =====
// Sampled half-width interpolator.
// The input channel (in_valid_i, in_stall_o) takes one command per transfer:
// clear both tables, append a (position, half-width) sample to the left or
// right table, or query both tables at a position. Every command gives one
// result transfer on the output channel (out_valid_o, out_stall_i).
// Clear and append pass through the execute and finish states, and their
// result is registered on leaving the finish state.
// A query runs both sides one after the other through one shared search,
// multiply and divide sequencer: per side a setup step, a check of each
// table end, the binary search steps (at most ceil(log2(TABLE_DEPTH))
// steps), a step to end the search, the fetch of the bracketing pair, the
// products and the bit-serial divide.
// The block takes a new command only when the sequencer is idle. A result
// that the receiver stalls is held in the output register, and the next
// command may still be taken and worked on until its own result is ready.
// Reset empties both tables (counts go to zero) and clears the output valid;
// table contents are not cleared.
module sampled_width_interpolator
  import swi_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             command_i,
  input  logic                   side_i,
  input  logic signed [PosW-1:0] position_i,
  input  logic [WidW-1:0]        width_sample_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [WidW-1:0]        left_half_o,
  output logic [WidW-1:0]        right_half_o,
  output logic [WidW:0]          total_width_o,
  output logic [WidW:0]          effective_width_o,
  output logic                   status_o
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(TABLE_DEPTH);

  state_e state_q, state_d;
  cmd_e   cmd_q;
  logic   aside_q;
  logic signed [PosW-1:0] pos_q;
  logic [WidW-1:0] wsmp_q;
  logic [CntW-1:0] lcnt_q, lcnt_d, rcnt_q, rcnt_d;
  logic            qside_q, qside_d;
  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [WidW-1:0] w1_q, w1_d, w2_q, w2_d;
  logic [PosW-1:0] dl_q, dl_d, dh_q, dh_d;
  logic [AccW-1:0] acc_q, acc_d, dv_q, dv_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [WidW-1:0] quo_q, quo_d;
  logic [3:0]      dcnt_q, dcnt_d;
  logic [WidW-1:0] lres_q, lres_d, rres_q, rres_d;
  logic            st_q, st_d;
  logic            out_load;

  logic [EntryW-1:0] rdata_l, rdata_r, rdata;
  logic signed [PosW-1:0] rpos;
  logic [WidW-1:0] rwid;
  logic            we_l, we_r;
  logic [CntW-1:0] ncnt;
  logic [CntW:0]   mid_sum;
  logic [PosW:0]   dsum;
  logic            done_side;
  logic [WidW-1:0] side_res;
  logic [WidW-1:0] mul_a;
  logic [PosW-1:0] mul_b;
  logic [ProdW-1:0] mul_p;

  swi_ram #(.WIDTH(EntryW), .DEPTH(TABLE_DEPTH)) u_left_ram (
    .clk_i  (clk_i),
    .we_i   (we_l),
    .waddr_i(lcnt_q[AddrW-1:0]),
    .wdata_i({pos_q, wsmp_q}),
    .raddr_i(addr_q),
    .rdata_o(rdata_l)
  );

  swi_ram #(.WIDTH(EntryW), .DEPTH(TABLE_DEPTH)) u_right_ram (
    .clk_i  (clk_i),
    .we_i   (we_r),
    .waddr_i(rcnt_q[AddrW-1:0]),
    .wdata_i({pos_q, wsmp_q}),
    .raddr_i(addr_q),
    .rdata_o(rdata_r)
  );

  assign rdata   = qside_q ? rdata_r : rdata_l;
  assign rpos    = rdata[EntryW-1:WidW];
  assign rwid    = rdata[WidW-1:0];
  assign ncnt    = qside_q ? rcnt_q : lcnt_q;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign dsum    = {1'b0, dh_q} + {1'b0, dl_q};

  // One multiplier shared by both products.
  assign mul_a = (state_q == ST_M1) ? w1_q : w2_q;
  assign mul_b = (state_q == ST_M1) ? dh_q : dl_q;
  assign mul_p = mul_a * mul_b;

  assign in_stall_o = (state_q != ST_IDLE);

  // Sequencer: command execution, per-side search, products and divide.
  always_comb begin
    state_d   = state_q;
    lcnt_d    = lcnt_q;
    rcnt_d    = rcnt_q;
    qside_d   = qside_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    addr_d    = addr_q;
    w1_d      = w1_q;
    w2_d      = w2_q;
    dl_d      = dl_q;
    dh_d      = dh_q;
    acc_d     = acc_q;
    prod_d    = prod_q;
    dv_d      = dv_q;
    quo_d     = quo_q;
    dcnt_d    = dcnt_q;
    lres_d    = lres_q;
    rres_d    = rres_q;
    st_d      = st_q;
    we_l      = 1'b0;
    we_r      = 1'b0;
    out_load  = 1'b0;
    done_side = 1'b0;
    side_res  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        lres_d  = '0;
        rres_d  = '0;
        st_d    = 1'b0;
        qside_d = 1'b0;
        state_d = ST_FIN;
        case (cmd_q)
          CMD_CLEAR: begin
            lcnt_d = '0;
            rcnt_d = '0;
          end
          CMD_APPEND: begin
            if (!aside_q) begin
              if (lcnt_q < DepthC) begin
                we_l   = 1'b1;
                lcnt_d = lcnt_q + 1'b1;
              end else begin
                st_d = 1'b1;
              end
            end else begin
              if (rcnt_q < DepthC) begin
                we_r   = 1'b1;
                rcnt_d = rcnt_q + 1'b1;
              end else begin
                st_d = 1'b1;
              end
            end
          end
          CMD_QUERY: state_d = ST_SETUP;
          default: ;
        endcase
      end
      ST_SETUP: begin
        if (ncnt == '0) begin
          done_side = 1'b1;
        end else begin
          addr_d  = '0;
          state_d = ST_W0;
        end
      end
      ST_W0: state_d = ST_C0;
      ST_C0: begin
        if (pos_q <= rpos) begin
          side_res  = rwid;
          done_side = 1'b1;
        end else begin
          addr_d  = AddrW'(ncnt - 1'b1);
          state_d = ST_W1;
        end
      end
      ST_W1: state_d = ST_C1;
      ST_C1: begin
        if (pos_q >= rpos) begin
          side_res  = rwid;
          done_side = 1'b1;
        end else begin
          lo_d    = '0;
          hi_d    = ncnt;
          state_d = ST_BS;
        end
      end
      ST_BS: begin
        if (lo_q + 1'b1 < hi_q) begin
          addr_d  = AddrW'(mid_sum >> 1);
          state_d = ST_BW;
        end else begin
          addr_d  = lo_q[AddrW-1:0];
          state_d = ST_LW;
        end
      end
      ST_BW: state_d = ST_BC;
      ST_BC: begin
        if (rpos <= pos_q) begin
          lo_d = CntW'(mid_sum >> 1);
        end else begin
          hi_d = CntW'(mid_sum >> 1);
        end
        state_d = ST_BS;
      end
      ST_LW: state_d = ST_LC;
      ST_LC: begin
        w1_d    = rwid;
        dl_d    = PosW'(pos_q - rpos);
        addr_d  = hi_q[AddrW-1:0];
        state_d = ST_HW;
      end
      ST_HW: state_d = ST_HC;
      ST_HC: begin
        w2_d    = rwid;
        dh_d    = PosW'(rpos - pos_q);
        state_d = ST_M1;
      end
      ST_M1: begin
        acc_d   = AccW'(mul_p);
        state_d = ST_M2;
      end
      ST_M2: begin
        prod_d  = mul_p;
        state_d = ST_M3;
      end
      ST_M3: begin
        acc_d   = acc_q + AccW'(prod_q) + AccW'(dsum >> 1);
        dv_d    = AccW'(dsum) << (WidW - 1);
        quo_d   = '0;
        dcnt_d  = 4'(WidW - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // Restoring divide, one quotient bit per cycle.
        if (acc_q >= dv_q) begin
          acc_d = acc_q - dv_q;
          quo_d = {quo_q[WidW-2:0], 1'b1};
        end else begin
          quo_d = {quo_q[WidW-2:0], 1'b0};
        end
        dv_d   = dv_q >> 1;
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == '0) begin
          side_res  = quo_d;
          done_side = 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_o || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // A side is finished: store it and move on to the right side or finish.
    if (done_side) begin
      if (!qside_q) begin
        lres_d  = side_res;
        qside_d = 1'b1;
        state_d = ST_SETUP;
      end else begin
        rres_d  = side_res;
        state_d = ST_FIN;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lcnt_q      <= '0;
      rcnt_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      lcnt_q  <= lcnt_d;
      rcnt_q  <= rcnt_d;
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      cmd_q   <= cmd_e'(command_i);
      aside_q <= side_i;
      pos_q   <= position_i;
      wsmp_q  <= width_sample_i;
    end
    qside_q <= qside_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    addr_q  <= addr_d;
    w1_q    <= w1_d;
    w2_q    <= w2_d;
    dl_q    <= dl_d;
    dh_q    <= dh_d;
    acc_q   <= acc_d;
    prod_q  <= prod_d;
    dv_q    <= dv_d;
    quo_q   <= quo_d;
    dcnt_q  <= dcnt_d;
    lres_q  <= lres_d;
    rres_q  <= rres_d;
    st_q    <= st_d;
    if (out_load) begin
      left_half_o       <= lres_q;
      right_half_o      <= rres_q;
      total_width_o     <= {1'b0, lres_q} + {1'b0, rres_q};
      effective_width_o <= (lres_q < rres_q) ? {lres_q, 1'b0} : {rres_q, 1'b0};
      status_o          <= st_q;
    end
  end

endmodule

// ===== tb/testbench.sv =====
module testbench
  import swi_pkg::*;
();

  localparam int unsigned Depth = 64;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        side;
    logic [31:0] pos;
    logic [15:0] wid;
  } cmd_item_t;

  typedef struct packed {
    logic [15:0] lw;
    logic [15:0] rw;
    logic [16:0] tw;
    logic [16:0] ew;
    logic        st;
  } width_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = CMD_CLEAR;
  logic        side_i = 1'b0;
  logic signed [31:0] position_i = '0;
  logic [15:0] width_sample_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] left_half_o;
  logic [15:0] right_half_o;
  logic [16:0] total_width_o;
  logic [16:0] effective_width_o;
  logic        status_o;

  sampled_width_interpolator u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .side_i, .position_i,
    .width_sample_i, .out_valid_o, .out_stall_i, .left_half_o, .right_half_o,
    .total_width_o, .effective_width_o, .status_o
  );

  // Predictor copy of both tables.
  logic signed [31:0] tbl_pos [2][Depth];
  logic [15:0]        tbl_wid [2][Depth];
  int unsigned        tbl_cnt [2];

  cmd_item_t  pending_q [$];
  width_res_t expected_q [$];
  int errors = 0;
  int idle_cycles = 0;
  int n_items = 0;
  int unsigned cyc_cnt = 0;
  int unsigned acc_cnt = 0;
  int unsigned seen_cnt = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [15:0] interp_side(int sd, logic signed [31:0] s);
    int unsigned n, lo, hi, mid;
    longint p1, p2, d;
    longint unsigned num;
    n = tbl_cnt[sd];
    if (n == 0) return 16'd0;
    if (s <= tbl_pos[sd][0]) return tbl_wid[sd][0];
    if (s >= tbl_pos[sd][n-1]) return tbl_wid[sd][n-1];
    lo = 0;
    hi = n;
    while (lo + 1 < hi) begin
      mid = (lo + hi) / 2;
      if (tbl_pos[sd][mid] <= s) lo = mid;
      else hi = mid;
    end
    p1 = tbl_pos[sd][lo];
    p2 = tbl_pos[sd][hi];
    d = p2 - p1;
    if (d <= 0) return tbl_wid[sd][lo];
    num = longint'(tbl_wid[sd][lo]) * (p2 - longint'(s))
        + longint'(tbl_wid[sd][hi]) * (longint'(s) - p1);
    num = (num + longint'(d) / 2) / longint'(d);
    if (num > 64'hFFFF) num = 64'hFFFF;
    return num[15:0];
  endfunction

  function automatic width_res_t predict_widths(cmd_item_t it);
    width_res_t r;
    int sd;
    r = '0;
    sd = it.side;
    case (it.cmd)
      CMD_CLEAR: begin
        tbl_cnt[0] = 0;
        tbl_cnt[1] = 0;
      end
      CMD_APPEND: begin
        if (tbl_cnt[sd] < Depth) begin
          tbl_pos[sd][tbl_cnt[sd]] = it.pos;
          tbl_wid[sd][tbl_cnt[sd]] = it.wid;
          tbl_cnt[sd]++;
        end else begin
          r.st = 1'b1;
        end
      end
      CMD_QUERY: begin
        r.lw = interp_side(0, it.pos);
        r.rw = interp_side(1, it.pos);
        r.tw = 17'(r.lw) + 17'(r.rw);
        r.ew = 17'(2 * ((r.lw < r.rw) ? r.lw : r.rw));
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  // Driver: bursts of transfers with random gaps, changed at the falling edge.
  int gap_left = 0;
  int burst_left = 0;
  always @(negedge clk_i) begin
    bit took;
    cmd_item_t cur;
    if (rst_ni) begin
      // A transfer happened at the last rising edge: predict its result.
      took = (acc_cnt != seen_cnt);
      if (took) begin
        seen_cnt = seen_cnt + 1;
        cur = pending_q.pop_front();
        expected_q = {expected_q, predict_widths(cur)};
      end
      if (!in_valid_i || took) begin
        if (pending_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          command_i <= pending_q[0].cmd;
          side_i <= pending_q[0].side;
          position_i <= pending_q[0].pos;
          width_sample_i <= pending_q[0].wid;
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60);
          end
        end
      end
      // Receiver stall pattern: phases of free flow, of light and of heavy stalling.
      out_stall_i <= (cyc_cnt[9]) ? ($urandom_range(0, 3) != 0) :
                     ((cyc_cnt[8]) ? 1'b0 : ($urandom_range(0, 4) == 0));
    end
  end

  // Monitor: checks each result transfer at the rising edge.
  always @(posedge clk_i) begin
    width_res_t w;
    cyc_cnt <= cyc_cnt + 1;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) acc_cnt <= acc_cnt + 1;
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          w = expected_q.pop_front();
          if (left_half_o !== w.lw) report_mismatch("left half", left_half_o, w.lw);
          if (right_half_o !== w.rw) report_mismatch("right half", right_half_o, w.rw);
          if (total_width_o !== w.tw) report_mismatch("total_width", total_width_o, w.tw);
          if (effective_width_o !== w.ew)
            report_mismatch("effective_width", effective_width_o, w.ew);
          if (status_o !== w.st) report_mismatch("status", status_o, w.st);
        end
      end
      if (idle_cycles >= WatchLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic cmd_item_t mk(int unsigned c, int unsigned sd, int unsigned p,
                                   int unsigned w);
    cmd_item_t it;
    it.cmd = 2'(c);
    it.side = 1'(sd);
    it.pos = p;
    it.wid = 16'(w);
    return it;
  endfunction

  task automatic queue_item(cmd_item_t it);
    pending_q = {pending_q, it};
    n_items++;
  endtask

  // Stimulus and end of run.
  initial begin
    int base;
    int sd;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: empty tables, ends, extremes, full table, unused command.
    queue_item(mk(CMD_QUERY, 0, 32'h8000_0000, 16'hFFFF));
    queue_item(mk(CMD_APPEND, 0, 32'h8000_0000, 16'hFFFF));
    queue_item(mk(CMD_APPEND, 0, 32'h7FFF_FFFF, 16'h0000));
    queue_item(mk(CMD_APPEND, 1, 32'h0000_0000, 16'h1234));
    queue_item(mk(CMD_QUERY, 1, 32'h8000_0000, 16'h0));
    queue_item(mk(CMD_QUERY, 0, 32'h7FFF_FFFF, 16'h0));
    queue_item(mk(CMD_QUERY, 0, 32'h0000_0000, 16'h0));
    queue_item(mk(CMD_QUERY, 0, 32'h0000_0001, 16'h0));
    queue_item(mk(CMD_NONE, 1, 32'hFFFF_FFFF, 16'hFFFF));
    queue_item(mk(CMD_CLEAR, 1, 32'hFFFF_FFFF, 16'hFFFF));
    queue_item(mk(CMD_QUERY, 0, 32'h0, 16'h0));
    // Duplicate positions and an unsorted pair on the right side.
    queue_item(mk(CMD_APPEND, 1, 32'd100, 16'd10));
    queue_item(mk(CMD_APPEND, 1, 32'd100, 16'd20));
    queue_item(mk(CMD_APPEND, 1, 32'd50, 16'd30));
    queue_item(mk(CMD_APPEND, 1, 32'd300, 16'hFFFF));
    queue_item(mk(CMD_QUERY, 0, 32'd101, 16'h0));
    queue_item(mk(CMD_QUERY, 0, 32'd200, 16'h0));
    queue_item(mk(CMD_CLEAR, 0, 32'h0, 16'h0));
    // Fill the left table and overflow it.
    for (int i = 0; i < Depth + 2; i++)
      queue_item(mk(CMD_APPEND, 0, i * 32'd1000 - 32'd20000, 16'($urandom)));
    queue_item(mk(CMD_QUERY, 0, 32'd12345, 16'h0));
    queue_item(mk(CMD_QUERY, 0, 32'h7FFF_FFFF, 16'h0));

    // Random: mostly sorted table builds with queries, with some noise.
    while (n_items < 700) begin
      queue_item(mk(CMD_CLEAR, $urandom, $urandom, $urandom));
      for (sd = 0; sd < 2; sd++) begin
        base = $urandom;
        base = ($urandom_range(0, 1)) ? -(base & 32'h3FFF_FFFF) : base;
        repeat ($urandom_range(0, ($urandom_range(0, 5) == 0) ? Depth + 3 : 10)) begin
          if ($urandom_range(0, 9) == 0)
            queue_item(mk(CMD_APPEND, sd, $urandom, $urandom));
          else begin
            queue_item(mk(CMD_APPEND, sd, base, $urandom));
            base = base + (($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1 << 20));
          end
        end
      end
      repeat ($urandom_range(2, 12)) begin
        case ($urandom_range(0, 9))
          0: queue_item(mk($urandom, $urandom, $urandom, $urandom));
          1: queue_item(mk(CMD_QUERY, $urandom, $urandom, $urandom));
          default: queue_item(mk(CMD_QUERY, $urandom, base - $urandom_range(0, 1 << 24),
                                 $urandom));
        endcase
      end
    end

    wait (pending_q.size() == 0 && !in_valid_i);
    wait (expected_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
